@@ sv/tae_pkg.sv @@
// ----------------------------------------------------------------------------
// tae_pkg
// Shared types and encoding constants for the thumb to arm expander.
// ----------------------------------------------------------------------------
package tae_pkg;

    // expanded word and its undefined flag
    typedef struct packed {
        logic [31:0] arm_word;
        logic        is_undefined;
    } result_t;

    // fixed words and conditions
    localparam logic [31:0] UNDEF_WORD = 32'hE7FF_FFFF;
    localparam logic [3:0]  COND_AL    = 4'hE;
    localparam logic [3:0]  COND_NV    = 4'hF;

    // thumb format groups, top nibble of the halfword
    localparam logic [3:0] FMT_SHIFT_LO  = 4'h0;
    localparam logic [3:0] FMT_SHIFT_HI  = 4'h1;
    localparam logic [3:0] FMT_IMM_LO    = 4'h2;
    localparam logic [3:0] FMT_IMM_HI    = 4'h3;
    localparam logic [3:0] FMT_ALU_HI    = 4'h4;
    localparam logic [3:0] FMT_LS_REG    = 4'h5;
    localparam logic [3:0] FMT_LS_IMM_W  = 4'h6;
    localparam logic [3:0] FMT_LS_IMM_B  = 4'h7;
    localparam logic [3:0] FMT_LS_HALF   = 4'h8;
    localparam logic [3:0] FMT_LS_SP     = 4'h9;
    localparam logic [3:0] FMT_ADDR      = 4'hA;
    localparam logic [3:0] FMT_MISC      = 4'hB;
    localparam logic [3:0] FMT_LDM_STM   = 4'hC;
    localparam logic [3:0] FMT_BCOND     = 4'hD;

    // sub-codes
    localparam logic [1:0] SHIFT_OP_ADDSUB = 2'd3;
    localparam logic [1:0] SEL_ALU         = 2'd0;
    localparam logic [1:0] SEL_HIREG       = 2'd1;
    localparam logic [1:0] HI_ADD          = 2'd0;
    localparam logic [1:0] HI_CMP          = 2'd1;
    localparam logic [1:0] HI_MOV          = 2'd2;
    localparam logic [3:0] ALU_LSL         = 4'd2;
    localparam logic [3:0] ALU_LSR         = 4'd3;
    localparam logic [3:0] ALU_ASR         = 4'd4;
    localparam logic [3:0] ALU_ROR         = 4'd7;
    localparam logic [3:0] ALU_NEG         = 4'd9;
    localparam logic [3:0] ALU_MUL         = 4'd13;
    localparam logic [7:0] HB_SP_ADJ       = 8'b1011_0000;
    localparam logic [7:0] HB_EXTEND       = 8'b1011_0010;
    localparam logic [7:0] HB_REVERSE      = 8'b1011_1010;
    localparam logic [1:0] MISC_PUSH_POP   = 2'b10;
    localparam logic [4:0] TOP5_BRANCH     = 5'b11100;
    localparam logic [3:0] MUL_MARK        = 4'b1001;

endpackage

@@ sv/tae_decode.sv @@
// ----------------------------------------------------------------------------
// tae_decode
// Combinational expansion of one thumb halfword into its arm word.
// ----------------------------------------------------------------------------
module tae_decode (
    input  logic [15:0]      thumb_halfword,
    output tae_pkg::result_t result
);

    logic [15:0] t;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic [2:0]  r8;
    logic [7:0]  imm8;
    logic [4:0]  off5;
    logic [27:0] w;
    logic [3:0]  cond;
    logic        undef;
    logic [3:0]  hd;
    logic [3:0]  hm;
    logic [27:0] hi_base;
    logic [1:0]  ty;
    logic        hs;
    logic        hh;
    logic        ll;
    logic [15:0] rlist;

    assign t    = thumb_halfword;
    assign rd   = t[2:0];
    assign rs   = t[5:3];
    assign r8   = t[10:8];
    assign imm8 = t[7:0];
    assign off5 = t[10:6];
    assign hd   = {t[7], rd};
    assign hm   = {t[6], rs};
    assign hi_base = {8'd0, hd, hd, 8'd0, hm};
    assign hs   = t[10];
    assign hh   = t[11];
    assign ll   = t[11];
    assign rlist = {t[8] & ll, t[8] & ~ll, 6'd0, imm8};

    // shift type for the register-shift alu ops
    always_comb
    begin
        case (t[9:6])
            tae_pkg::ALU_LSL: ty = 2'd0;
            tae_pkg::ALU_LSR: ty = 2'd1;
            tae_pkg::ALU_ASR: ty = 2'd2;
            default:          ty = 2'd3;
        endcase
    end

    // format decode
    always_comb
    begin
        w     = 28'd0;
        cond  = tae_pkg::COND_AL;
        undef = 1'b0;
        case (t[15:12])
            tae_pkg::FMT_SHIFT_LO, tae_pkg::FMT_SHIFT_HI:
            begin
                if (t[12:11] != tae_pkg::SHIFT_OP_ADDSUB)
                begin
                    w = {3'b000, 4'hD, 1'b1, 4'hF, 1'b0, rd, off5, t[12:11], 2'b00, rs};
                end
                else
                begin
                    w = {2'b00, t[10], (t[9] ? 4'd2 : 4'd4), 1'b1, 1'b0, rs, 1'b0, rd,
                         9'd0, t[8:6]};
                end
            end
            tae_pkg::FMT_IMM_LO, tae_pkg::FMT_IMM_HI:
            begin
                case (t[12:11])
                    2'd0:    w[24:21] = 4'hD;
                    2'd1:    w[24:21] = 4'hA;
                    2'd2:    w[24:21] = 4'h4;
                    default: w[24:21] = 4'h2;
                endcase
                w[25]    = 1'b1;
                w[20]    = 1'b1;
                w[19:16] = {1'b0, r8};
                w[15:12] = {1'b0, r8};
                w[7:0]   = imm8;
            end
            tae_pkg::FMT_ALU_HI:
            begin
                if (t[11:10] == tae_pkg::SEL_ALU)
                begin
                    if (t[9:6] inside {tae_pkg::ALU_LSL, tae_pkg::ALU_LSR,
                                       tae_pkg::ALU_ASR, tae_pkg::ALU_ROR})
                    begin
                        w = {3'b000, 4'hD, 1'b1, 1'b0, rd, 1'b0, rd, 1'b0, rs, 1'b0, ty,
                             1'b1, 1'b0, rd};
                    end
                    else if (t[9:6] == tae_pkg::ALU_NEG)
                    begin
                        w = {2'b00, 1'b1, 4'd3, 1'b1, 1'b0, rs, 1'b0, rd, 12'd0};
                    end
                    else if (t[9:6] == tae_pkg::ALU_MUL)
                    begin
                        w = {7'd0, 1'b1, 1'b0, rd, 4'd0, 1'b0, rd, tae_pkg::MUL_MARK,
                             1'b0, rs};
                    end
                    else
                    begin
                        w = {3'b000, t[9:6], 1'b1, 1'b0, rd, 1'b0, rd, 9'd0, rs};
                    end
                end
                else if (t[11:10] == tae_pkg::SEL_HIREG)
                begin
                    case (t[9:8])
                        tae_pkg::HI_ADD: w = hi_base | (28'h4 << 21);
                        tae_pkg::HI_CMP: w = hi_base | (28'hA << 21) | (28'd1 << 20);
                        tae_pkg::HI_MOV: w = hi_base | (28'hD << 21);
                        default:
                        begin
                            w = hi_base | (28'h12 << 20) | ({27'd0, t[7]} << 5) |
                                (28'd1 << 4);
                        end
                    endcase
                end
                else
                begin
                    w = {1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 2'b00, 1'b1, 4'hF, 1'b0, r8,
                         2'b00, imm8, 2'b00};
                end
            end
            tae_pkg::FMT_LS_REG:
            begin
                if (!t[9])
                begin
                    w = {1'b0, 4'b1111, t[10], 1'b0, t[11], 1'b0, rs, 1'b0, rd, 9'd0,
                         t[8:6]};
                end
                else
                begin
                    w = {3'b000, 2'b11, 2'b00, hs | hh, 1'b0, rs, 1'b0, rd, 4'hF, 1'b1, hs,
                         (~hs) | hh, 1'b1, 1'b0, t[8:6]};
                end
            end
            tae_pkg::FMT_LS_IMM_W, tae_pkg::FMT_LS_IMM_B:
            begin
                w = {1'b0, 1'b1, 1'b0, 2'b11, t[12], 1'b0, t[11], 1'b0, rs, 1'b0, rd, 5'd0,
                     (t[12] ? {2'b00, off5} : {off5, 2'b00})};
            end
            tae_pkg::FMT_LS_HALF:
            begin
                w = {3'b000, 3'b111, 1'b0, t[11], 1'b0, rs, 1'b0, rd, 2'b00, off5[4:3],
                     4'b1011, off5[2:0], 1'b0};
            end
            tae_pkg::FMT_LS_SP:
            begin
                w = {1'b0, 1'b1, 1'b0, 2'b11, 2'b00, t[11], 4'd13, 1'b0, r8, 2'b00, imm8,
                     2'b00};
            end
            tae_pkg::FMT_ADDR:
            begin
                w = {2'b00, 1'b1, 4'd4, 1'b0, (t[11] ? 4'd13 : 4'd15), 1'b0, r8, 2'b00,
                     imm8, 2'b00};
            end
            tae_pkg::FMT_MISC:
            begin
                if (t[15:8] == tae_pkg::HB_SP_ADJ)
                begin
                    w = {2'b00, 1'b1, (t[7] ? 4'd2 : 4'd4), 1'b0, 4'd13, 4'd13, 3'd0,
                         t[6:0], 2'b00};
                end
                else if (t[10:9] == tae_pkg::MISC_PUSH_POP)
                begin
                    w = {3'b100, ~ll, ll, 1'b0, 1'b1, ll, 4'd13, rlist};
                end
                else if (t[15:8] == tae_pkg::HB_EXTEND)
                begin
                    w = {1'b0, 4'hD, t[7], 1'b1, ~t[6], 4'hF, 1'b0, rd, 4'd0, 4'd7, 1'b0,
                         rs};
                end
                else if (t[15:8] == tae_pkg::HB_REVERSE)
                begin
                    w = {1'b0, 4'hD, t[7], 1'b1, 1'b1, 4'hF, 1'b0, rd, 4'd0, t[6], 3'd3,
                         1'b0, rs};
                end
                else
                begin
                    undef = 1'b1;
                end
            end
            tae_pkg::FMT_LDM_STM:
            begin
                w = {3'b100, 1'b0, 1'b1, 1'b0, 1'b1, t[11], 1'b0, r8, 8'd0, imm8};
            end
            tae_pkg::FMT_BCOND:
            begin
                if (t[11:8] != tae_pkg::COND_NV)
                begin
                    cond = t[11:8];
                    w    = {3'b101, 1'b0, {16{imm8[7]}}, imm8};
                end
                else
                begin
                    w = {4'hF, 16'd0, imm8};
                end
            end
            default:
            begin
                // unconditional branch and the two long branch halves
                if (t[15:11] == tae_pkg::TOP5_BRANCH)
                begin
                    w = {3'b101, 1'b0, {13{t[10]}}, t[10:0]};
                end
                else if (t[11])
                begin
                    w = {3'b101, 1'b1, 1'b0, 1'b1, 11'd0, t[10:0]};
                    if (!t[12])
                    begin
                        cond = tae_pkg::COND_NV;
                    end
                end
                else
                begin
                    w = {3'b101, 1'b1, 2'b00, t[10:0], 11'd0};
                end
            end
        endcase
    end

    // final word
    assign result.arm_word     = undef ? tae_pkg::UNDEF_WORD : {cond, w};
    assign result.is_undefined = undef;

endmodule

@@ sv/thumb_to_arm_instruction_expander.sv @@
// ----------------------------------------------------------------------------
// thumb_to_arm_instruction_expander
// Expands 16-bit thumb instructions into 32-bit arm instruction words.
// ----------------------------------------------------------------------------
// an accepted word passes the input reg, then the result reg, which drives result valid
// throughput: one word per cycle while out_ready holds, set by the single-pass decode between regs
// the input register refills in the cycle its word moves on to the result reg
// reset: rst_n async active low empties both stages, payload regs not reset
module thumb_to_arm_instruction_expander (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] thumb_halfword,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] arm_word,
    output logic        is_undefined
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [15:0]      s1_hw_reg;
    logic             s2_valid_reg;
    logic             s2_valid_next;
    tae_pkg::result_t s2_result_reg;
    tae_pkg::result_t dec_result;
    logic             s2_load;
    logic             s1_load;

    // stage advance control
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load || (s2_valid_reg && !out_ready);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_hw_reg <= thumb_halfword;
        end
    end

    // expansion logic
    tae_decode u_decode (
        .thumb_halfword (s1_hw_reg),
        .result         (dec_result)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_result_reg <= dec_result;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign arm_word     = s2_result_reg.arm_word;
    assign is_undefined = s2_result_reg.is_undefined;

    // checks
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_load |=> s1_valid_reg && $stable(s1_hw_reg))
        else $error("input stage lost or changed a stalled word");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted word did not reach the input stage");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("empty input stage not ready");

    a_undef_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_undefined |-> arm_word == tae_pkg::UNDEF_WORD)
        else $error("undefined flag without the undefined word");

endmodule
